// ----- src/cbds_pkg.sv -----
// ----------------------------------------------------------------------------
// cbds_pkg
// Shared constants, register codes and types of the discharge select unit.
// ----------------------------------------------------------------------------
package cbds_pkg;

  localparam int unsigned NUM_MODULES = 36;
  localparam int unsigned IDX_W       = $clog2(NUM_MODULES);
  localparam int unsigned CNT_W       = $clog2(NUM_MODULES + 1);
  localparam int unsigned VOLT_W      = 16;
  localparam int unsigned LIMIT_W     = VOLT_W + 1;
  localparam int unsigned MASK_W      = 36;
  localparam int unsigned OUT_IDX_W   = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [VOLT_W-1:0] THR_RESET = 16'd40000;
  localparam logic [VOLT_W-1:0] TOL_RESET = 16'd500;

  localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_TOL     = 2'd1;

  typedef struct packed {
    logic [NUM_MODULES-1:0] en_flags;
    logic [VOLT_W-1:0]      min_volt;
    logic [IDX_W-1:0]       min_idx;
    logic                   any_en;
    logic [CNT_W-1:0]       count;
  } scan_info_t;

  typedef enum logic [1:0] {
    ST_SCAN  = 2'b01,
    ST_SWEEP = 2'b10
  } state_e;

endpackage

// ----- src/cbds_store.sv -----
// ----------------------------------------------------------------------------
// cbds_store
// Voltage store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbds_store import cbds_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_addr_i,
  input  logic [VOLT_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [IDX_W-1:0]  rd_addr_i,
  output logic [VOLT_W-1:0] rd_data_o
);

  logic [VOLT_W-1:0] mem_q [NUM_MODULES];
  logic [VOLT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/cbds_scan.sv -----
// ----------------------------------------------------------------------------
// cbds_scan
// Item intake: module counter, enable flags, running minimum, store writes.
// ----------------------------------------------------------------------------
module cbds_scan import cbds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [VOLT_W-1:0] volt_i,
  input  logic              en_i,
  input  logic              clr_i,
  output scan_info_t        info_o,
  output logic              wr_en_o,
  output logic [IDX_W-1:0]  wr_addr_o,
  output logic [VOLT_W-1:0] wr_data_o
);

  scan_info_t info_q, info_d;
  logic       room;
  logic [IDX_W-1:0] idx;

  assign room = info_q.count < CNT_W'(NUM_MODULES);
  assign idx  = info_q.count[IDX_W-1:0];

  always_comb begin
    info_d = info_q;
    if (clr_i) begin
      info_d.en_flags = '0;
      info_d.min_volt = '1;
      info_d.min_idx  = '0;
      info_d.any_en   = 1'b0;
      info_d.count    = '0;
    end else if (acc_i && room) begin
      info_d.count = info_q.count + CNT_W'(1);
      if (en_i) begin
        info_d.en_flags[idx] = 1'b1;
        if (!info_q.any_en || (volt_i < info_q.min_volt)) begin
          info_d.min_volt = volt_i;
          info_d.min_idx  = idx;
          info_d.any_en   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_q.en_flags <= '0;
      info_q.min_volt <= '1;
      info_q.min_idx  <= '0;
      info_q.any_en   <= 1'b0;
      info_q.count    <= '0;
    end else begin
      info_q <= info_d;
    end
  end

  assign info_o    = info_q;
  assign wr_en_o   = acc_i && room;
  assign wr_addr_o = idx;
  assign wr_data_o = volt_i;

endmodule

// ----- src/cbds_sweep.sv -----
// ----------------------------------------------------------------------------
// cbds_sweep
// Final pass: reads each stored voltage once and builds the discharge mask.
// ----------------------------------------------------------------------------
module cbds_sweep import cbds_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   go_i,
  input  scan_info_t             info_i,
  input  logic [LIMIT_W-1:0]     limit_i,
  output logic                   rd_en_o,
  output logic [IDX_W-1:0]       rd_addr_o,
  input  logic [VOLT_W-1:0]      rd_data_i,
  output logic                   done_o,
  output logic [NUM_MODULES-1:0] dch_o
);

  logic                   active_q, active_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   cmp_vld_q, cmp_last_q, cmp_last_d;
  logic [IDX_W-1:0]       cmp_idx_q;
  logic [NUM_MODULES-1:0] dch_q, dch_d;
  logic                   done_q, done_d;
  logic                   last_issue;

  assign last_issue = (CNT_W'(rd_idx_q) + CNT_W'(1)) == info_i.count;

  always_comb begin
    active_d   = active_q;
    rd_idx_d   = rd_idx_q;
    dch_d      = dch_q;
    cmp_last_d = active_q && last_issue;
    done_d     = cmp_vld_q && cmp_last_q;
    if (go_i) begin
      active_d = 1'b1;
      rd_idx_d = '0;
      dch_d    = '0;
    end else if (active_q) begin
      rd_idx_d = rd_idx_q + IDX_W'(1);
      if (last_issue) begin
        active_d = 1'b0;
      end
    end
    if (cmp_vld_q) begin
      dch_d[cmp_idx_q] = info_i.en_flags[cmp_idx_q] && ({1'b0, rd_data_i} > limit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      cmp_idx_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      active_q   <= active_d;
      rd_idx_q   <= rd_idx_d;
      cmp_vld_q  <= active_q;
      cmp_last_q <= cmp_last_d;
      cmp_idx_q  <= rd_idx_q;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dch_q <= dch_d;
  end

  assign rd_en_o   = active_q;
  assign rd_addr_o = rd_idx_q;
  assign done_o    = done_q;
  assign dch_o     = dch_q;

`ifndef ASSERT_OFF
  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (CNT_W'(cmp_idx_q) < info_i.count))
    else $error("compare index beyond scanned modules");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!active_q && !cmp_vld_q))
    else $error("sweep done while reads outstanding");
`endif

endmodule

// ----- src/cell_balance_discharge_select_unit.sv -----
// ----------------------------------------------------------------------------
// cell_balance_discharge_select_unit
// Stores module voltages, tracks the minimum and selects modules to discharge.
// ----------------------------------------------------------------------------
// An item is taken at each edge with start high and busy low; busy stays
// low while a scan loads. After the item with last_module, busy is high
// until the sweep, one store read per module stored in the scan, is done;
// the result strobe is registered from that done flag, for one cycle.
// Reset clears the scan state and loads the register defaults; the store
// keeps no reset. The result receiver cannot stall.
module cell_balance_discharge_select_unit import cbds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VOLT_W-1:0]     cell_voltage_i,
  input  logic                  module_enabled_i,
  input  logic                  last_module_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  result_valid_o,
  output logic [MASK_W-1:0]     discharge_mask_o,
  output logic [MASK_W-1:0]     update_mask_o,
  output logic [VOLT_W-1:0]     minimum_voltage_o,
  output logic [OUT_IDX_W-1:0]  minimum_index_o,
  output logic                  below_threshold_mode_o
);

  state_e                 state_q, state_d;
  logic [VOLT_W-1:0]      thr_q, tol_q;
  logic                   acc, go, swp_done;
  scan_info_t             info;
  logic                   wr_en, rd_en;
  logic [IDX_W-1:0]       wr_addr, rd_addr;
  logic [VOLT_W-1:0]      wr_data, rd_data;
  logic [NUM_MODULES-1:0] dch;
  logic                   below;
  logic [LIMIT_W-1:0]     limit;
  logic [NUM_MODULES+MASK_W-1:0] dch_ext, upd_ext;

  logic                   valid_q;
  logic [MASK_W-1:0]      dch_mask_q, upd_mask_q;
  logic [VOLT_W-1:0]      min_volt_q;
  logic [OUT_IDX_W-1:0]   min_idx_q;
  logic                   below_q;

  assign busy = (state_q != ST_SCAN);
  assign acc  = start && !busy;
  assign go   = acc && last_module_i;

  assign below = info.any_en && (info.min_volt < thr_q);
  assign limit = below ? {1'b0, thr_q}
                       : ({1'b0, info.min_volt} + {1'b0, tol_q});

  assign dch_ext = {{MASK_W{1'b0}}, dch};
  assign upd_ext = {{MASK_W{1'b0}}, info.en_flags};

  cbds_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .volt_i    (cell_voltage_i),
    .en_i      (module_enabled_i),
    .clr_i     (swp_done),
    .info_o    (info),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  cbds_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  cbds_sweep u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .info_i    (info),
    .limit_i   (limit),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .done_o    (swp_done),
    .dch_o     (dch)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SCAN: begin
        if (go) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (swp_done) begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_SCAN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SCAN;
      valid_q <= 1'b0;
      thr_q   <= THR_RESET;
      tol_q   <= TOL_RESET;
    end else begin
      state_q <= state_d;
      valid_q <= swp_done;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_START_THRESHOLD: thr_q <= cfg_data_i[VOLT_W-1:0];
          REG_BALANCE_TOL:     tol_q <= cfg_data_i[VOLT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (swp_done) begin
      dch_mask_q <= dch_ext[MASK_W-1:0];
      upd_mask_q <= upd_ext[MASK_W-1:0];
      min_volt_q <= info.any_en ? info.min_volt : '0;
      min_idx_q  <= info.any_en ? OUT_IDX_W'(info.min_idx) : '0;
      below_q    <= below;
    end
  end

  assign result_valid_o         = valid_q;
  assign discharge_mask_o       = dch_mask_q;
  assign update_mask_o          = upd_mask_q;
  assign minimum_voltage_o      = min_volt_q;
  assign minimum_index_o        = min_idx_q;
  assign below_threshold_mode_o = below_q;

`ifndef ASSERT_OFF
  a_done_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swp_done |-> (state_q == ST_SWEEP))
    else $error("sweep done outside sweep state");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> busy)
    else $error("not busy after final item");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule
